@@ sv/hsvc_pkg.sv @@
package hsvc_pkg;

	// Channel width and the widths that follow from it.
	localparam int CB    = 16;
	localparam int DW    = CB + 3;
	localparam int QB    = CB + 1;
	localparam int NUM_W = DW + QB;
	localparam int MW    = 2 * CB + 1;
	localparam int SW    = DW + 1;

	// Depth of the queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// Fixed-point constants: full scale, one turn and one half.
	localparam logic [CB-1:0] CH_MAX     = {CB{1'b1}};
	localparam logic [CB:0]   ONE_TURN   = {1'b1, {CB{1'b0}}};
	localparam logic [CB-1:0] ROUND_HALF = {1'b1, {(CB-1){1'b0}}};

	// Conversion direction codes.
	localparam logic DIR_HSB2RGB = 1'b0;
	localparam logic DIR_RGB2HSB = 1'b1;

	// One classified color as it waits in the queue.
	typedef struct packed {
		logic            dir;
		logic            black;
		logic            grey;
		logic [2:0]      sector;
		logic [CB-1:0]   a;
		logic [CB-1:0]   b;
		logic [CB-1:0]   c;
		logic [DW-1:0]   r1;
		logic [DW-1:0]   r2;
		logic [QB-1:0]   l1;
		logic [QB-1:0]   l2;
		logic [DW-1:0]   d1;
		logic [DW-1:0]   d2;
	} item_t;

	// One color inside the back pipeline.
	typedef struct packed {
		item_t         it;
		logic [MW-1:0] m0;
		logic [MW-1:0] m1;
		logic [MW-1:0] m2;
		logic [QB-1:0] q1;
		logic [QB-1:0] q2;
	} stage_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	// Rounded division by full scale, done as a shift estimate with one correction.
	function automatic logic [CB-1:0] div_max_rnd(input logic [MW-1:0] x);
		logic [MW:0] y;
		logic [MW:0] q0;
		logic [MW:0] r;
		y  = {1'b0, x} + (MW+1)'(ROUND_HALF - 1'b1);
		q0 = (y + (y >> CB)) >> CB;
		r  = y - (q0 << CB) + q0;
		if (r >= (MW+1)'(CH_MAX)) begin
			q0 = q0 + 1'b1;
		end
		return q0[CB-1:0];
	endfunction

endpackage

@@ sv/hsvc_ifs.sv @@
interface hsvc_cfg_if;
	logic valid;
	logic ready;
	logic direction;
	modport source (output valid, output direction, input ready);
	modport sink (input valid, input direction, output ready);
endinterface

interface hsvc_in_if;
	logic                    valid;
	logic                    ready;
	logic [hsvc_pkg::CB-1:0] in_first;
	logic [hsvc_pkg::CB-1:0] in_second;
	logic [hsvc_pkg::CB-1:0] in_third;
	modport source (output valid, output in_first, output in_second, output in_third,
		input ready);
	modport sink (input valid, input in_first, input in_second, input in_third,
		output ready);
endinterface

interface hsvc_out_if;
	logic                    valid;
	logic                    ready;
	logic [hsvc_pkg::CB-1:0] out_first;
	logic [hsvc_pkg::CB-1:0] out_second;
	logic [hsvc_pkg::CB-1:0] out_third;
	modport source (output valid, output out_first, output out_second, output out_third,
		input ready);
	modport sink (input valid, input out_first, input out_second, input out_third,
		output ready);
endinterface

@@ sv/hsvc_front.sv @@
module hsvc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              direction,
	hsvc_in_if.sink           pixel,
	input  hsvc_pkg::qstat_t  qstat,
	output logic              push,
	output hsvc_pkg::item_t   push_item
);

	logic              f_vld_q;
	hsvc_pkg::item_t   f_item_q;
	hsvc_pkg::item_t   cls;
	logic [hsvc_pkg::DW-1:0]    h6;
	logic [hsvc_pkg::CB-1:0]    mx;
	logic [hsvc_pkg::CB-1:0]    mn;
	logic [hsvc_pkg::CB-1:0]    delta;
	logic [hsvc_pkg::DW-1:0]    d6;
	logic [hsvc_pkg::SW-1:0]    n;
	logic [hsvc_pkg::NUM_W-1:0] num1;
	logic [hsvc_pkg::NUM_W-1:0] num2;

	// The front register takes a transaction whenever it can hand its own on.
	assign pixel.ready = !f_vld_q || !qstat.full;
	assign push        = f_vld_q && !qstat.full;
	assign push_item   = f_item_q;

	// Classify the color: sector and fraction, or extremes, hue numerator and dividends.
	always_comb begin
		cls   = '0;
		h6    = hsvc_pkg::DW'({pixel.in_first, 2'b00}) + hsvc_pkg::DW'({pixel.in_first, 1'b0});
		mx    = pixel.in_first;
		mn    = pixel.in_first;
		if (pixel.in_second > mx) begin
			mx = pixel.in_second;
		end
		if (pixel.in_third > mx) begin
			mx = pixel.in_third;
		end
		if (pixel.in_second < mn) begin
			mn = pixel.in_second;
		end
		if (pixel.in_third < mn) begin
			mn = pixel.in_third;
		end
		delta = mx - mn;
		d6    = hsvc_pkg::DW'({delta, 2'b00}) + hsvc_pkg::DW'({delta, 1'b0});
		if (pixel.in_first == mx) begin
			n = hsvc_pkg::SW'(pixel.in_second) - hsvc_pkg::SW'(pixel.in_third);
		end else if (pixel.in_second == mx) begin
			n = hsvc_pkg::SW'({delta, 1'b0}) + hsvc_pkg::SW'(pixel.in_third)
				- hsvc_pkg::SW'(pixel.in_first);
		end else begin
			n = hsvc_pkg::SW'({delta, 2'b00}) + hsvc_pkg::SW'(pixel.in_first)
				- hsvc_pkg::SW'(pixel.in_second);
		end
		if (n[hsvc_pkg::SW-1]) begin
			n = n + hsvc_pkg::SW'(d6);
		end
		num1 = (hsvc_pkg::NUM_W'(delta) << hsvc_pkg::CB) - hsvc_pkg::NUM_W'(delta)
			+ hsvc_pkg::NUM_W'(mx >> 1);
		num2 = (hsvc_pkg::NUM_W'(n[hsvc_pkg::DW-1:0]) << hsvc_pkg::CB)
			+ hsvc_pkg::NUM_W'({delta, 1'b0}) + hsvc_pkg::NUM_W'(delta);

		cls.dir = direction;
		if (direction == hsvc_pkg::DIR_HSB2RGB) begin
			cls.black  = (pixel.in_third == '0);
			cls.grey   = (pixel.in_second == '0);
			cls.sector = h6[hsvc_pkg::DW-1:hsvc_pkg::CB];
			cls.a      = h6[hsvc_pkg::CB-1:0];
			cls.b      = pixel.in_second;
			cls.c      = pixel.in_third;
		end else begin
			cls.grey = (delta == '0);
			cls.c    = mx;
			cls.r1   = num1[hsvc_pkg::NUM_W-1:hsvc_pkg::QB];
			cls.l1   = num1[hsvc_pkg::QB-1:0];
			cls.d1   = hsvc_pkg::DW'(mx);
			cls.r2   = num2[hsvc_pkg::NUM_W-1:hsvc_pkg::QB];
			cls.l2   = num2[hsvc_pkg::QB-1:0];
			cls.d2   = d6;
		end
	end

	// Front valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_vld_q <= 1'b0;
		end else if (pixel.valid && pixel.ready) begin
			f_vld_q <= 1'b1;
		end else if (!qstat.full) begin
			f_vld_q <= 1'b0;
		end
	end

	// Front payload.
	always_ff @(posedge clk) begin
		if (pixel.valid && pixel.ready) begin
			f_item_q <= cls;
		end
	end

endmodule

@@ sv/hsvc_queue.sv @@
module hsvc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hsvc_pkg::item_t  push_item,
	input  logic             pop,
	output hsvc_pkg::item_t  head,
	output hsvc_pkg::qstat_t qstat
);

	hsvc_pkg::item_t                 mem_q [hsvc_pkg::QDEPTH];
	logic [hsvc_pkg::QAW-1:0]        wp_q;
	logic [hsvc_pkg::QAW-1:0]        rp_q;
	logic [hsvc_pkg::QAW:0]          cnt_q;

	assign head        = mem_q[rp_q];
	assign qstat.empty = (cnt_q == '0);
	assign qstat.full  = (cnt_q == (hsvc_pkg::QAW+1)'(hsvc_pkg::QDEPTH));

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_item;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full) else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty) else $error("pop from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (hsvc_pkg::QAW+1)'(hsvc_pkg::QDEPTH)) else $error("queue count out of range");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count lost a push");
`endif

endmodule

@@ sv/hsvc_back.sv @@
module hsvc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  hsvc_pkg::item_t  head,
	input  hsvc_pkg::qstat_t qstat,
	output logic             pop,
	hsvc_out_if.source       result
);

	localparam int NS = hsvc_pkg::QB;

	logic                    stg_vld_q [NS];
	hsvc_pkg::stage_t        stg_q [NS];
	hsvc_pkg::stage_t        stg_nx [NS];
	logic                    res_vld_q;
	logic [hsvc_pkg::CB-1:0] res0_q;
	logic [hsvc_pkg::CB-1:0] res1_q;
	logic [hsvc_pkg::CB-1:0] res2_q;
	logic [hsvc_pkg::CB-1:0] fin0;
	logic [hsvc_pkg::CB-1:0] fin1;
	logic [hsvc_pkg::CB-1:0] fin2;
	logic                    en;

	// The whole pipeline moves when the output register is free or being taken.
	assign en  = !res_vld_q || result.ready;
	assign pop = en && !qstat.empty;

	// Each stage does one step of both dividers; the first three also do the HSB math.
	for (genvar i = 0; i < NS; i++) begin : g_stg
		hsvc_pkg::stage_t            cur;
		logic [hsvc_pkg::DW:0]       t1;
		logic [hsvc_pkg::DW:0]       t2;
		logic                        ge1;
		logic                        ge2;
		logic [hsvc_pkg::CB-1:0]     sf;
		logic [hsvc_pkg::CB-1:0]     sg;
		logic [hsvc_pkg::CB-1:0]     p;
		logic [hsvc_pkg::CB-1:0]     q;
		logic [hsvc_pkg::CB-1:0]     t;

		assign cur = stg_q[i];

		always_comb begin
			stg_nx[i] = cur;
			sf = '0;
			sg = '0;
			p  = '0;
			q  = '0;
			t  = '0;

			// Restoring division step, one quotient bit per divider.
			t1  = {cur.it.r1, cur.it.l1[hsvc_pkg::QB-1]};
			t2  = {cur.it.r2, cur.it.l2[hsvc_pkg::QB-1]};
			ge1 = (t1 >= {1'b0, cur.it.d1});
			ge2 = (t2 >= {1'b0, cur.it.d2});
			stg_nx[i].it.r1 = ge1 ? hsvc_pkg::DW'(t1 - {1'b0, cur.it.d1}) : t1[hsvc_pkg::DW-1:0];
			stg_nx[i].it.r2 = ge2 ? hsvc_pkg::DW'(t2 - {1'b0, cur.it.d2}) : t2[hsvc_pkg::DW-1:0];
			stg_nx[i].it.l1 = {cur.it.l1[hsvc_pkg::QB-2:0], 1'b0};
			stg_nx[i].it.l2 = {cur.it.l2[hsvc_pkg::QB-2:0], 1'b0};
			stg_nx[i].q1    = {cur.q1[hsvc_pkg::QB-2:0], ge1};
			stg_nx[i].q2    = {cur.q2[hsvc_pkg::QB-2:0], ge2};

			// Saturation times the sector fraction and its complement.
			if (i == 0 && cur.it.dir == hsvc_pkg::DIR_HSB2RGB) begin
				stg_nx[i].m0 = hsvc_pkg::MW'(cur.it.b) * hsvc_pkg::MW'(cur.it.a);
				stg_nx[i].m1 = hsvc_pkg::MW'(cur.it.b)
					* (hsvc_pkg::MW'(hsvc_pkg::ONE_TURN) - hsvc_pkg::MW'(cur.it.a));
			end

			// Round those and scale brightness by the three complements.
			if (i == 1 && cur.it.dir == hsvc_pkg::DIR_HSB2RGB) begin
				sf = hsvc_pkg::CB'((cur.m0 + hsvc_pkg::MW'(hsvc_pkg::ROUND_HALF)) >> hsvc_pkg::CB);
				sg = hsvc_pkg::CB'((cur.m1 + hsvc_pkg::MW'(hsvc_pkg::ROUND_HALF)) >> hsvc_pkg::CB);
				stg_nx[i].m0 = hsvc_pkg::MW'(cur.it.c) * hsvc_pkg::MW'(hsvc_pkg::CH_MAX - cur.it.b);
				stg_nx[i].m1 = hsvc_pkg::MW'(cur.it.c) * hsvc_pkg::MW'(hsvc_pkg::CH_MAX - sf);
				stg_nx[i].m2 = hsvc_pkg::MW'(cur.it.c) * hsvc_pkg::MW'(hsvc_pkg::CH_MAX - sg);
			end

			// Divide by full scale and place the values by hue sector.
			if (i == 2 && cur.it.dir == hsvc_pkg::DIR_HSB2RGB) begin
				p = hsvc_pkg::div_max_rnd(cur.m0);
				q = hsvc_pkg::div_max_rnd(cur.m1);
				t = hsvc_pkg::div_max_rnd(cur.m2);
				case (cur.it.sector)
					3'd0: begin
						stg_nx[i].it.a = cur.it.c; stg_nx[i].it.b = t; stg_nx[i].it.c = p;
					end
					3'd1: begin
						stg_nx[i].it.a = q; stg_nx[i].it.b = cur.it.c; stg_nx[i].it.c = p;
					end
					3'd2: begin
						stg_nx[i].it.a = p; stg_nx[i].it.b = cur.it.c; stg_nx[i].it.c = t;
					end
					3'd3: begin
						stg_nx[i].it.a = p; stg_nx[i].it.b = q; stg_nx[i].it.c = cur.it.c;
					end
					3'd4: begin
						stg_nx[i].it.a = t; stg_nx[i].it.b = p; stg_nx[i].it.c = cur.it.c;
					end
					default: begin
						stg_nx[i].it.a = cur.it.c; stg_nx[i].it.b = p; stg_nx[i].it.c = q;
					end
				endcase
				if (cur.it.black) begin
					stg_nx[i].it.a = '0;
					stg_nx[i].it.b = '0;
					stg_nx[i].it.c = '0;
				end else if (cur.it.grey) begin
					stg_nx[i].it.a = cur.it.c;
					stg_nx[i].it.b = cur.it.c;
					stg_nx[i].it.c = cur.it.c;
				end
			end
		end
	end

	// Result fields out of the last stage.
	always_comb begin
		if (stg_nx[NS-1].it.dir == hsvc_pkg::DIR_HSB2RGB) begin
			fin0 = stg_nx[NS-1].it.a;
			fin1 = stg_nx[NS-1].it.b;
			fin2 = stg_nx[NS-1].it.c;
		end else if (stg_nx[NS-1].it.grey) begin
			fin0 = '0;
			fin1 = '0;
			fin2 = stg_nx[NS-1].it.c;
		end else begin
			fin0 = stg_nx[NS-1].q2[hsvc_pkg::CB-1:0];
			fin1 = stg_nx[NS-1].q1[hsvc_pkg::CB-1:0];
			fin2 = stg_nx[NS-1].it.c;
		end
	end

	// Stage and output valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) begin
				stg_vld_q[k] <= 1'b0;
			end
			res_vld_q <= 1'b0;
		end else if (en) begin
			stg_vld_q[0] <= !qstat.empty;
			for (int k = 1; k < NS; k++) begin
				stg_vld_q[k] <= stg_vld_q[k-1];
			end
			res_vld_q <= stg_vld_q[NS-1];
		end
	end

	// Stage and output payloads.
	always_ff @(posedge clk) begin
		if (en) begin
			stg_q[0] <= '{it: head, default: '0};
			for (int k = 1; k < NS; k++) begin
				stg_q[k] <= stg_nx[k-1];
			end
			res0_q <= fin0;
			res1_q <= fin1;
			res2_q <= fin2;
		end
	end

	assign result.valid      = res_vld_q;
	assign result.out_first  = res0_q;
	assign result.out_second = res1_q;
	assign result.out_third  = res2_q;

endmodule

@@ sv/hsv_rgb_color_converter.sv @@
// Channel  Role    Handshake      Payload
// cfg      sink    valid/ready    direction (0 HSB to RGB, 1 RGB to HSB)
// pixel    sink    valid/ready    in_first, in_second, in_third
// result   source  valid/ready    out_first, out_second, out_third
//
// One color is accepted per cycle while nothing stalls; result.valid rises once its input
// transaction has passed the front register, the queue, the 17 divider stages and the
// output register.
// The pipeline depth is set by the two bit-serial dividers, one quotient bit a stage.
// Reset clears all valid flags, the queue and the direction register to HSB to RGB.
// A stalled result freezes the back pipeline; the four-entry queue and the front
// register keep accepting until they fill. Configuration writes are always taken.
module hsv_rgb_color_converter (
	input  logic        clk,
	input  logic        arst_n,
	hsvc_cfg_if.sink    cfg,
	hsvc_in_if.sink     pixel,
	hsvc_out_if.source  result
);

	logic              direction_q;
	logic              push;
	logic              pop;
	hsvc_pkg::item_t   push_item;
	hsvc_pkg::item_t   head;
	hsvc_pkg::qstat_t  qstat;

	// Direction register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= hsvc_pkg::DIR_HSB2RGB;
		end else if (cfg.valid && cfg.ready) begin
			direction_q <= cfg.direction;
		end
	end

	// Front: accept and classify.
	hsvc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.direction (direction_q),
		.pixel     (pixel),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	// Queue between front and back.
	hsvc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// Back: arithmetic pipeline and output register.
	hsvc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.result (result)
	);

endmodule
